@@ rtl/websocket_frame_deframer_defines.svh @@
// ----------------------------------------------------------------------------
// WebSocket frame deframer assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Check a property at every rising edge outside reset.
`define WSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define WSD_NEVER(lbl, cond, msg) \
    `WSD_ASSERT(lbl, !(cond), msg)

`endif

@@ rtl/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Widths, phase and status codes, result record and helper functions.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int LengthWidth = 64;
    localparam int OutLenWidth = 64;

    typedef logic [LengthWidth-1:0] t_len;

    // parse phases
    localparam logic [2:0] PhHdr0  = 3'd0;
    localparam logic [2:0] PhHdr1  = 3'd1;
    localparam logic [2:0] PhExt16 = 3'd2;
    localparam logic [2:0] PhExt64 = 3'd3;
    localparam logic [2:0] PhKey   = 3'd4;
    localparam logic [2:0] PhPay   = 3'd5;

    // frame status codes
    localparam logic [1:0] StatusBusy  = 2'd0;
    localparam logic [1:0] StatusReady = 2'd1;
    localparam logic [1:0] StatusTrunc = 2'd2;

    // byte kinds
    localparam logic KindHeader  = 1'b0;
    localparam logic KindPayload = 1'b1;

    // seven-bit length codes that announce an extended length
    localparam logic [6:0] LenCode16 = 7'd126;
    localparam logic [6:0] LenCode64 = 7'd127;

    localparam logic [2:0] Ext16Bytes = 3'd2;
    localparam logic [2:0] KeyBytes   = 3'd4;

    typedef struct packed {
        logic [7:0]             out_byte;
        logic                   byte_kind;
        logic                   frame_fin;
        logic [2:0]             rsv_bits;
        logic [3:0]             frame_opcode;
        logic                   frame_masked;
        logic [OutLenWidth-1:0] payload_length;
        logic [1:0]             frame_status;
    } t_result;

    // Shift one big-endian length byte in; saturate when it would overflow.
    function automatic t_len push_len(t_len acc, logic [7:0] b);
        if (acc[LengthWidth-1 -: 8] != 8'd0) begin
            return '1;
        end
        return {acc[LengthWidth-9:0], b};
    endfunction

    // Key byte for a payload index: index 0 takes the first key byte received.
    function automatic logic [7:0] key_byte(logic [31:0] key, logic [1:0] idx);
        logic [1:0] sel;
        sel = 2'd3 - idx;
        return key[{sel, 3'b000} +: 8];
    endfunction

endpackage

@@ rtl/websocket_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses RFC 6455 frame headers from a byte stream and emits unmasked payload.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+-----------------------------------------
//  in      | i_in_valid / o_in_stall   | i_in_byte, i_end_of_data
//  out     | o_out_valid / i_out_stall | o_out_byte, o_byte_kind, o_frame_fin,
//          |                           | o_rsv_bits, o_frame_opcode,
//          |                           | o_frame_masked, o_payload_length,
//          |                           | o_frame_status
//  cfg     | i_cfg_we                  | i_cfg_data (unmask enable)
//
//  One transaction in gives one transaction out via the result register, at
//  one byte per clock while o_in_stall is low; the limit is the parse step (64-bit
//  count compare). A two-entry output stage (result register plus skid register)
//  lets the input take one more byte after the output stalls.
//  Reset is synchronous, active low; it returns parsing to the first header
//  byte and sets unmask enable.
//  o_in_stall is registered: it rises only while the skid register is full.
//
`include "websocket_frame_deframer_defines.svh"

module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_data,
    // byte stream in
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_in_byte,
    input  logic                   i_end_of_data,
    // parsed bytes out
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [7:0]             o_out_byte,
    output logic                   o_byte_kind,
    output logic                   o_frame_fin,
    output logic [2:0]             o_rsv_bits,
    output logic [3:0]             o_frame_opcode,
    output logic                   o_frame_masked,
    output logic [OutLenWidth-1:0] o_payload_length,
    output logic [1:0]             o_frame_status
);

    // parser state
    logic [2:0]  r_phase, n_phase;
    logic [2:0]  r_hc, n_hc;
    t_len        r_len, n_len;
    logic [31:0] r_key, n_key;
    t_len        r_cnt, n_cnt;
    logic        r_fin, n_fin;
    logic [2:0]  r_rsv, n_rsv;
    logic [3:0]  r_opc, n_opc;
    logic        r_masked, n_masked;
    logic        r_unmask;

    // output stage
    t_result     r_out, r_skid, n_res;
    logic        r_out_valid, r_skid_valid;

    logic        in_acc;
    logic        out_free;
    logic        done;
    logic [7:0]  ob;
    logic        kind;

    assign in_acc   = i_in_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    // ---------------------------------------------------------------
    // Parse step: one byte against the current phase.
    // ---------------------------------------------------------------
    always_comb begin
        n_phase  = r_phase;
        n_hc     = r_hc;
        n_len    = r_len;
        n_key    = r_key;
        n_cnt    = r_cnt;
        n_fin    = r_fin;
        n_rsv    = r_rsv;
        n_opc    = r_opc;
        n_masked = r_masked;
        done     = 1'b0;
        ob       = 8'd0;
        kind     = KindHeader;

        unique case (r_phase)
            PhHdr1: begin
                n_masked = i_in_byte[7];
                n_hc     = 3'd0;
                if (i_in_byte[6:0] == LenCode16) begin
                    n_len   = '0;
                    n_phase = PhExt16;
                end else if (i_in_byte[6:0] == LenCode64) begin
                    n_len   = '0;
                    n_phase = PhExt64;
                end else begin
                    n_len = LengthWidth'(i_in_byte[6:0]);
                    // length known: key, payload, or an empty frame
                    if (n_masked) begin
                        n_phase = PhKey;
                    end else if (n_len == '0) begin
                        done = 1'b1;
                    end else begin
                        n_phase = PhPay;
                    end
                end
            end
            PhExt16, PhExt64: begin
                n_len = push_len(r_len, i_in_byte);
                n_hc  = r_hc + 3'd1;
                if ((r_phase == PhExt16 && n_hc == Ext16Bytes) ||
                    (r_phase == PhExt64 && n_hc == 3'd0)) begin
                    n_hc = 3'd0;
                    if (r_masked) begin
                        n_phase = PhKey;
                    end else if (n_len == '0) begin
                        done = 1'b1;
                    end else begin
                        n_phase = PhPay;
                    end
                end
            end
            PhKey: begin
                n_key = {r_key[23:0], i_in_byte};
                n_hc  = r_hc + 3'd1;
                if (n_hc == KeyBytes) begin
                    n_hc = 3'd0;
                    if (r_len == '0) begin
                        done = 1'b1;
                    end else begin
                        n_phase = PhPay;
                    end
                end
            end
            PhPay: begin
                kind = KindPayload;
                ob   = i_in_byte;
                if (r_unmask && r_masked) begin
                    ob = i_in_byte ^ key_byte(r_key, r_cnt[1:0]);
                end
                n_cnt = r_cnt + t_len'(1);
                if (n_cnt >= r_len) begin
                    done = 1'b1;
                end
            end
            default: begin
                // first header byte; unused phase codes land here too
                n_fin    = i_in_byte[7];
                n_rsv    = i_in_byte[6:4];
                n_opc    = i_in_byte[3:0];
                n_masked = 1'b0;
                n_len    = '0;
                n_key    = '0;
                n_cnt    = '0;
                n_hc     = 3'd0;
                n_phase  = PhHdr1;
            end
        endcase

        // restart at a new header after completion or truncation
        if (done || i_end_of_data) begin
            n_phase = PhHdr0;
            n_hc    = 3'd0;
        end

        n_res.out_byte       = ob;
        n_res.byte_kind      = kind;
        n_res.frame_fin      = n_fin;
        n_res.rsv_bits       = n_rsv;
        n_res.frame_opcode   = n_opc;
        n_res.frame_masked   = n_masked;
        n_res.payload_length = OutLenWidth'(n_len);
        n_res.frame_status   = done ? StatusReady
                                    : (i_end_of_data ? StatusTrunc : StatusBusy);
    end

    // ---------------------------------------------------------------
    // Parser state advances on every accepted byte, unmask enable on i_cfg_we.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PhHdr0;
            r_hc     <= 3'd0;
            r_len    <= '0;
            r_key    <= '0;
            r_cnt    <= '0;
            r_fin    <= 1'b0;
            r_rsv    <= 3'd0;
            r_opc    <= 4'd0;
            r_masked <= 1'b0;
            r_unmask <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_unmask <= i_cfg_data;
            end
            if (in_acc) begin
                r_phase  <= n_phase;
                r_hc     <= n_hc;
                r_len    <= n_len;
                r_key    <= n_key;
                r_cnt    <= n_cnt;
                r_fin    <= n_fin;
                r_rsv    <= n_rsv;
                r_opc    <= n_opc;
                r_masked <= n_masked;
            end
        end
    end

    // ---------------------------------------------------------------
    // Output stage: result register backed by one skid register.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // drain skid first; it is never full while a byte is accepted
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_acc) begin
                r_out <= n_res;
            end
        end else if (in_acc) begin
            r_skid <= n_res;
        end
    end

    assign o_in_stall       = r_skid_valid;
    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out.out_byte;
    assign o_byte_kind      = r_out.byte_kind;
    assign o_frame_fin      = r_out.frame_fin;
    assign o_rsv_bits       = r_out.rsv_bits;
    assign o_frame_opcode   = r_out.frame_opcode;
    assign o_frame_masked   = r_out.frame_masked;
    assign o_payload_length = r_out.payload_length;
    assign o_frame_status   = r_out.frame_status;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `WSD_NEVER(a_skid_behind_out, r_skid_valid && !r_out_valid,
               "skid register full while result register empty")

    `WSD_NEVER(a_key_count, r_phase == PhKey && r_hc >= KeyBytes,
               "masking key byte count out of range")

    `WSD_NEVER(a_ext16_count, r_phase == PhExt16 && r_hc >= Ext16Bytes,
               "16-bit length byte count out of range")

    `WSD_NEVER(a_pay_count, r_phase == PhPay && r_cnt >= r_len,
               "payload count reached length without restart")

    `WSD_ASSERT(a_restart, in_acc && n_res.frame_status != StatusBusy |=> r_phase == PhHdr0,
                "parser did not restart after ready or truncation")

endmodule

@@ tb/sv/websocket_frame_deframer_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket deframer result checker
// Watches both channels and the unmask register write, predicts each parsed
// byte record, and compares every output transaction with the oldest one.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_check
    import wsd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [7:0]             i_in_byte,
    input  logic                   i_end_of_data,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [7:0]             i_out_byte,
    input  logic                   i_byte_kind,
    input  logic                   i_frame_fin,
    input  logic [2:0]             i_rsv_bits,
    input  logic [3:0]             i_frame_opcode,
    input  logic                   i_frame_masked,
    input  logic [OutLenWidth-1:0] i_payload_length,
    input  logic [1:0]             i_frame_status,
    output int                     o_fail_count,
    output int                     o_expect_count
);

    localparam t_len LenMax = '1;

    // parser copy
    logic [2:0]  phase;
    logic [2:0]  hdr_cnt;
    t_len        len_acc;
    logic [31:0] key_word;
    t_len        pay_index;
    logic        fin_q;
    logic [2:0]  rsv_q;
    logic [3:0]  opc_q;
    logic        mask_q;
    logic        unmask_q;

    t_result     parsed_q[$];
    t_result     want;
    int          mismatches = 0;

    // Length is known: move on to the key, the payload, or finish the frame.
    function automatic logic length_known();
        hdr_cnt = '0;
        if (mask_q) begin
            phase = PhKey;
            return 1'b0;
        end
        if (len_acc == '0) begin
            return 1'b1;
        end
        phase = PhPay;
        return 1'b0;
    endfunction

    task automatic deframe_byte(input logic [7:0] b, input logic eod);
        t_result    r;
        logic       done;
        logic [7:0] kb;
        r    = '0;
        done = 1'b0;
        case (phase)
            PhHdr1: begin
                mask_q = b[7];
                if (b[6:0] == LenCode16) begin
                    len_acc = '0;
                    hdr_cnt = '0;
                    phase   = PhExt16;
                end else if (b[6:0] == LenCode64) begin
                    len_acc = '0;
                    hdr_cnt = '0;
                    phase   = PhExt64;
                end else begin
                    len_acc = t_len'(b[6:0]);
                    done    = length_known();
                end
            end
            PhExt16, PhExt64: begin
                // saturate rather than lose high bits
                if (len_acc > (LenMax >> 8)) begin
                    len_acc = LenMax;
                end else begin
                    len_acc = (len_acc << 8) | t_len'(b);
                end
                hdr_cnt = hdr_cnt + 3'd1;
                if ((phase == PhExt16 && hdr_cnt == Ext16Bytes) ||
                    (phase == PhExt64 && hdr_cnt == 3'd0)) begin
                    done = length_known();
                end
            end
            PhKey: begin
                key_word = {key_word[23:0], b};
                hdr_cnt  = hdr_cnt + 3'd1;
                if (hdr_cnt == KeyBytes) begin
                    hdr_cnt = '0;
                    if (len_acc == '0) begin
                        done = 1'b1;
                    end else begin
                        phase = PhPay;
                    end
                end
            end
            PhPay: begin
                // payload index 0 pairs with the first key byte received
                kb          = 8'(key_word >> {~pay_index[1:0], 3'b000});
                r.byte_kind = KindPayload;
                r.out_byte  = (unmask_q && mask_q) ? (b ^ kb) : b;
                pay_index   = pay_index + 1'b1;
                if (pay_index >= len_acc) begin
                    done = 1'b1;
                end
            end
            default: begin
                fin_q     = b[7];
                rsv_q     = b[6:4];
                opc_q     = b[3:0];
                mask_q    = 1'b0;
                len_acc   = '0;
                key_word  = '0;
                pay_index = '0;
                hdr_cnt   = '0;
                phase     = PhHdr1;
            end
        endcase
        r.frame_fin      = fin_q;
        r.rsv_bits       = rsv_q;
        r.frame_opcode   = opc_q;
        r.frame_masked   = mask_q;
        r.payload_length = OutLenWidth'(len_acc);
        r.frame_status   = done ? StatusReady : (eod ? StatusTrunc : StatusBusy);
        if (done || eod) begin
            phase   = PhHdr0;
            hdr_cnt = '0;
        end
        parsed_q.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v,
                     got_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase     = PhHdr0;
            hdr_cnt   = '0;
            len_acc   = '0;
            key_word  = '0;
            pay_index = '0;
            fin_q     = 1'b0;
            rsv_q     = '0;
            opc_q     = '0;
            mask_q    = 1'b0;
            unmask_q  = 1'b1;
            parsed_q.delete();
        end else begin
            // results first: an input taken at this edge cannot answer yet
            if (i_out_valid && !i_out_stall) begin
                if (parsed_q.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual byte %0h",
                             $time, i_out_byte);
                    mismatches++;
                end else begin
                    want = parsed_q.pop_front();
                    check_field("out_byte", 64'(want.out_byte), 64'(i_out_byte));
                    check_field("byte_kind", 64'(want.byte_kind), 64'(i_byte_kind));
                    check_field("frame_fin", 64'(want.frame_fin), 64'(i_frame_fin));
                    check_field("rsv_bits", 64'(want.rsv_bits), 64'(i_rsv_bits));
                    check_field("frame_opcode", 64'(want.frame_opcode),
                                64'(i_frame_opcode));
                    check_field("frame_masked", 64'(want.frame_masked),
                                64'(i_frame_masked));
                    check_field("payload_length", 64'(want.payload_length),
                                64'(i_payload_length));
                    check_field("frame_status", 64'(want.frame_status),
                                64'(i_frame_status));
                end
            end
            if (i_cfg_we) begin
                unmask_q = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                deframe_byte(i_in_byte, i_end_of_data);
            end
        end
        o_expect_count <= parsed_q.size();
        o_fail_count   <= mismatches;
    end

endmodule

@@ tb/sv/websocket_frame_deframer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket deframer testbench
// Drives a byte stream of directed and random frames through the deframer
// under random input gaps and output stalls, flips the unmask register between
// phases, and leaves prediction and comparison to the checker beside it.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_test
    import wsd_pkg::*;
();

    localparam int HoldCycles  = 80;  // length of the long receiver hold-off
    localparam int DrainCycles = 6;   // quiet cycles after the last result
    localparam int IdlePct     = 34;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic                   i_cfg_data    = 1'b0;
    logic                   i_in_valid    = 1'b0;
    logic [7:0]             i_in_byte     = '0;
    logic                   i_end_of_data = 1'b0;
    logic                   i_out_stall   = 1'b0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [7:0]             o_out_byte;
    logic                   o_byte_kind;
    logic                   o_frame_fin;
    logic [2:0]             o_rsv_bits;
    logic [3:0]             o_frame_opcode;
    logic                   o_frame_masked;
    logic [OutLenWidth-1:0] o_payload_length;
    logic [1:0]             o_frame_status;

    int   fail_count;
    int   expect_count;
    int   items_sent     = 0;
    bit   jitter_on      = 1'b0;  // both sides idle at random while set
    logic hold_off_go    = 1'b0;  // asks the receiver for one long stall
    logic hold_off_taken = 1'b0;  // set by the receiver once it has stalled

    // {end_of_data, byte} pairs for the directed opening
    logic [8:0] directed_q[$] = '{
        // all header bits set, empty unmasked frame: ready on second byte
        9'h0FF, 9'h000,
        // empty masked frame: ready on the last key byte
        9'h000, 9'h080, 9'h0DE, 9'h0AD, 9'h0BE, 9'h0EF,
        // masked, 16-bit length of 1 (non-minimal), end of data on the
        // completing byte: ready wins over truncation
        9'h082, 9'h0FE, 9'h000, 9'h001, 9'h001, 9'h002, 9'h004, 9'h008, 9'h1A5,
        // 64-bit length cut short while its bytes are still arriving
        9'h001, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,
        // end of data on a first header byte
        9'h188
    };

    websocket_frame_deframer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .i_end_of_data   (i_end_of_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_byte_kind     (o_byte_kind),
        .o_frame_fin     (o_frame_fin),
        .o_rsv_bits      (o_rsv_bits),
        .o_frame_opcode  (o_frame_opcode),
        .o_frame_masked  (o_frame_masked),
        .o_payload_length(o_payload_length),
        .o_frame_status  (o_frame_status)
    );

    websocket_frame_deframer_check u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .i_end_of_data   (i_end_of_data),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_out_byte      (o_out_byte),
        .i_byte_kind     (o_byte_kind),
        .i_frame_fin     (o_frame_fin),
        .i_rsv_bits      (o_rsv_bits),
        .i_frame_opcode  (o_frame_opcode),
        .i_frame_masked  (o_frame_masked),
        .i_payload_length(o_payload_length),
        .i_frame_status  (o_frame_status),
        .o_fail_count    (fail_count),
        .o_expect_count  (expect_count)
    );

    initial begin
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    // Receiver: random stalls while jitter is on, otherwise ready but for the hold-off.
    // A hold-off request gives it one long stall, taken only once.
    initial begin
        forever begin
            if (hold_off_go && !hold_off_taken) begin
                hold_off_taken = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HoldCycles) @(posedge i_clk);
            end else begin
                i_out_stall <= jitter_on && ($urandom_range(99) < IdlePct);
                @(posedge i_clk);
            end
        end
    end

    // Offer one byte; returns right after the edge that accepts it. Any
    // random gap comes first, so valid is never dropped and raised in one step.
    task automatic send_byte(input logic [7:0] b, input logic eod);
        while (jitter_on && ($urandom_range(99) < IdlePct)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in_byte     <= b;
        i_end_of_data <= eod;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // Drop valid, wait for every predicted record, then let the pipe empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expect_count != 0);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_unmask(input logic v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // One well-formed frame with random content. Long lengths are always
    // cut by end of data no later than the 31st payload byte; short ones sometimes.
    task automatic send_frame();
        logic [7:0]  b0;
        logic [7:0]  b;
        logic        masked;
        logic [6:0]  code;
        logic [63:0] len;
        logic [31:0] key;
        logic        eod;
        logic        eod_last;
        int          ext_n;
        int          hdr_n;
        int          total;
        int          cut;
        int          sel;
        b0       = 8'($urandom);
        masked   = 1'($urandom_range(1));
        key      = $urandom;
        eod_last = ($urandom_range(19) == 0);
        sel      = $urandom_range(99);
        if (sel < 60) begin
            ext_n = 0;
            len   = ($urandom_range(9) == 0) ? 64'($urandom_range(125))
                                             : 64'($urandom_range(12));
            code  = len[6:0];
        end else if (sel < 85) begin
            ext_n = 2;
            code  = LenCode16;
            len   = ($urandom_range(7) == 0) ? 64'($urandom_range(65535))
                                             : 64'($urandom_range(40));
        end else begin
            ext_n = 8;
            code  = LenCode64;
            len   = ($urandom_range(3) == 0) ? {$urandom, $urandom}
                                             : 64'($urandom_range(40));
        end
        hdr_n = 2 + ext_n + (masked ? 4 : 0);
        if (len > 150) begin
            total = hdr_n + 31;
            cut   = $urandom_range(hdr_n + 30);
        end else begin
            total = hdr_n + int'(len);
            cut   = ($urandom_range(99) < 12) ? int'($urandom_range(total - 1)) : -1;
        end
        for (int pos = 0; pos < total; pos++) begin
            if (pos == 0) begin
                b = b0;
            end else if (pos == 1) begin
                b = {masked, code};
            end else if (pos < 2 + ext_n) begin
                // extended length goes out big-endian
                b = 8'(len >> (8 * (ext_n - 1 - (pos - 2))));
            end else if (pos < hdr_n) begin
                b = 8'(key >> (8 * (3 - (pos - 2 - ext_n))));
            end else begin
                b = 8'($urandom);
            end
            eod = (pos == cut) || ((pos == total - 1) && eod_last);
            send_byte(b, eod);
            if (pos == cut) begin
                break;
            end
        end
    endtask

    // A few raw bytes, then an end of data to bring parsing back to a header.
    task automatic send_noise();
        repeat ($urandom_range(1, 6)) begin
            send_byte(8'($urandom), $urandom_range(3) == 0);
        end
        send_byte(8'($urandom), 1'b1);
    endtask

    task automatic run_random(input int n);
        int target;
        target = items_sent + n;
        while (items_sent < target) begin
            if ($urandom_range(99) < 5) begin
                send_noise();
            end else begin
                send_frame();
            end
        end
    endtask

    // Stimulus and verdict.
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opening with unmasking at its reset value
        foreach (directed_q[i]) begin
            send_byte(directed_q[i][7:0], directed_q[i][8]);
        end
        settle();

        // masked payload passes through untouched
        write_unmask(1'b0);
        jitter_on = 1'b1;
        run_random(450);
        settle();

        // long receiver hold-off with the sender pushing flat out
        write_unmask(1'b1);
        jitter_on = 1'b0;
        hold_off_go <= 1'b1;
        run_random(450);

        // sender pauses until the block has answered everything
        settle();
        jitter_on = 1'b1;
        run_random(450);
        settle();

        write_unmask(1'b0);
        jitter_on = 1'b0;
        run_random(250);
        settle();

        write_unmask(1'b1);
        jitter_on = 1'b1;
        run_random(250);
        settle();

        if (fail_count == 0) begin
            $display("websocket_frame_deframer_test: done, clean");
        end else begin
            $display("websocket_frame_deframer_test: done, errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("websocket_frame_deframer_test: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/wsd_pkg.sv
rtl/websocket_frame_deframer.sv
tb/sv/websocket_frame_deframer_check.sv
tb/sv/websocket_frame_deframer_test.sv
